// ===== src/rpha_pkg.sv =====
// ----------------------------------------------------------------------------
// rpha_pkg
// Types and constants shared by the resource pool health allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rpha_pkg;

  localparam int MASK_W      = 8;
  localparam int MAX_ENTRIES = 32;
  localparam int MAX_IDX_W   = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_THRESHOLD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECOVERIES    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_BASE_MS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BACKOFF_SHIFT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUIRE_SECURE    = 3'd4;

  localparam logic [9:0] MS_PER_SECOND = 10'd1000;

  // x / 1000 = (x >> 3) / 125; y = hi * 2^22 + lo, with 2^22 = 125 * 33554 + 54
  // and the last quotient by 125 taken as (z * ceil(2^36 / 125)) >> 36.
  localparam int BK_W      = 48;
  localparam int BK_PRE_SH = 3;
  localparam int BK_Y_W    = BK_W - BK_PRE_SH;
  localparam int BK_SPLIT  = 22;
  localparam int BK_HI_W   = BK_Y_W - BK_SPLIT;
  localparam int BK_Z_W    = 29;
  localparam int BK_RCP_W  = 30;
  localparam int BK_RCP_SH = 36;
  localparam int BK_PROD_W = BK_Z_W + BK_RCP_W;
  localparam int BK_QUO_W  = 39;

  localparam logic [5:0]          BK_HI_REM = 6'd54;
  localparam logic [15:0]         BK_HI_QUO = 16'd33554;
  localparam logic [BK_RCP_W-1:0] BK_RCP    = 30'd549755814;

  localparam int DIV_STEPS = 2;
  localparam int DIV_CNT_W = 1;
  localparam int SUM_W     = BK_QUO_W + 1;
  localparam int TIME_W    = 32;

  typedef enum logic [1:0] {
    ES_AVAILABLE = 2'd0,
    ES_IN_USE    = 2'd1,
    ES_DEAD      = 2'd2,
    ES_PERMANENT = 2'd3
  } entry_state_e;

  typedef enum logic [2:0] {
    SR_PASS,
    SR_RETIRE,
    SR_RECON_FAIL,
    SR_BUMP,
    SR_SUCCESS
  } scan_res_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_DIV,
    S_DEADLINE,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic [7:0]  dead_threshold;
    logic [7:0]  max_recoveries;
    logic [15:0] backoff_base_ms;
    logic [4:0]  max_backoff_shift;
    logic        require_secure;
  } cfg_t;

  typedef struct packed {
    logic              action;
    logic [31:0]       now_seconds;
    logic [2:0]        entry_index;
    logic              use_failed;
    logic [MASK_W-1:0] link_ok_mask;
    logic [MASK_W-1:0] reconnect_ok_mask;
    logic [MASK_W-1:0] secure_ok_mask;
    logic [MASK_W-1:0] prepare_ok_mask;
  } req_t;

  typedef struct packed {
    logic        granted;
    logic [2:0]  grant_index;
    logic        became_dead;
    logic [3:0]  healthy_total;
    logic [31:0] failures_total;
    logic [31:0] resets_total;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic release_apply;
    logic pick;
    logic scan_apply;
    logic scan_next;
    logic div_step;
    logic deadline;
  } dp_cmd_t;

  typedef struct packed {
    logic      is_release;
    logic      pick_found;
    scan_res_e scan_res;
    logic      scan_last;
    logic      div_done;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== src/resource_pool_health_allocator.sv =====
// ----------------------------------------------------------------------------
// resource_pool_health_allocator
// Pool of entries with health tracking, dead marking and backoff recovery.
//
//   channel   signals                          handshake
//   request   start, req_i                     taken when start && !busy
//   result    done_o, rsp_o                    one-cycle strobe, no stall
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i write on cfg_we_i
//
// A release, or an acquire that finds an available healthy entry, goes from
// the decode state straight to the done state, which strobes done_o; the
// block accepts again once back in idle. An acquire that finds none walks
// the entries in order in the scan state; each failed reconnect adds the
// backoff quotient division steps and a state that stores the retry time.
// Reset is asynchronous and leaves the pool ready; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module resource_pool_health_allocator
  import rpha_pkg::*;
#(
  parameter int POOL_ENTRIES = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  input  req_t                       req_i,
  output logic                       busy,
  output logic                       done_o,
  output rsp_t                       rsp_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    busy_int;

  rpha_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rpha_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_int),
    .done_o  (done_o)
  );

  rpha_dp #(
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

  assign busy = busy_int;

endmodule

`default_nettype wire

// ===== src/rpha_cfg.sv =====
// ----------------------------------------------------------------------------
// rpha_cfg
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module rpha_cfg
  import rpha_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dead_threshold    <= 8'd3;
      cfg_q.max_recoveries    <= 8'd5;
      cfg_q.backoff_base_ms   <= 16'd1000;
      cfg_q.max_backoff_shift <= 5'd6;
      cfg_q.require_secure    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEAD_THRESHOLD:    cfg_q.dead_threshold    <= cfg_wdata_i[7:0];
        CFG_MAX_RECOVERIES:    cfg_q.max_recoveries    <= cfg_wdata_i[7:0];
        CFG_BACKOFF_BASE_MS:   cfg_q.backoff_base_ms   <= cfg_wdata_i;
        CFG_MAX_BACKOFF_SHIFT: cfg_q.max_backoff_shift <= cfg_wdata_i[4:0];
        CFG_REQUIRE_SECURE:    cfg_q.require_secure    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== src/rpha_dp.sv =====
// ----------------------------------------------------------------------------
// rpha_dp
// Entry tables, counters, scan pointer, backoff divider and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rpha_dp
  import rpha_pkg::*;
#(
  parameter int POOL_ENTRIES = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cfg_t      cfg_i,
  input  req_t      req_i,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o,
  output rsp_t      rsp_o
);

  localparam int IDX_W = $clog2(POOL_ENTRIES);
  localparam int HC_W  = $clog2(POOL_ENTRIES + 1);

  req_t            req_q;
  entry_state_e    status_q [POOL_ENTRIES];
  logic [7:0]      err_q    [POOL_ENTRIES];
  logic [7:0]      rc_q     [POOL_ENTRIES];
  logic [31:0]     retry_q  [POOL_ENTRIES];
  logic [HC_W-1:0] hc_q;
  logic [31:0]     fail_q;
  logic [31:0]     reset_q;
  logic [IDX_W-1:0] scan_q;
  logic            granted_q;
  logic [IDX_W-1:0] gidx_q;
  logic            dead_q;
  logic [BK_Y_W-1:0]    y_q;
  logic [BK_Z_W-1:0]    z_q;
  logic [BK_QUO_W-1:0]  qh_q;
  logic [BK_QUO_W-1:0]  quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;

  logic [MAX_ENTRIES-1:0] link_ext;
  logic [MAX_ENTRIES-1:0] recon_ext;
  logic [MAX_ENTRIES-1:0] secure_ext;
  logic [MAX_ENTRIES-1:0] prep_ext;
  logic [MAX_IDX_W-1:0]   scan_ext;

  logic             pick_found;
  logic [IDX_W-1:0] pick_idx;
  scan_res_e        scan_res;
  logic [7:0]       rc_inc;
  logic [4:0]       shift_amt;

  logic [BK_W-1:0]      bk_x;
  logic [BK_HI_W-1:0]   y_hi;
  logic [BK_SPLIT-1:0]  y_lo;
  logic [BK_PROD_W-1:0] prod;

  logic [SUM_W-1:0]  sum;
  logic [TIME_W-1:0] deadline;

  logic             rel_in_use;
  logic [IDX_W-1:0] rel_idx;
  logic [7:0]       err_inc;
  logic             rel_dead;

  assign link_ext   = MAX_ENTRIES'(req_q.link_ok_mask);
  assign recon_ext  = MAX_ENTRIES'(req_q.reconnect_ok_mask);
  assign secure_ext = MAX_ENTRIES'(req_q.secure_ok_mask);
  assign prep_ext   = MAX_ENTRIES'(req_q.prepare_ok_mask);
  assign scan_ext   = MAX_IDX_W'(scan_q);

  always_comb begin
    pick_found = 1'b0;
    pick_idx   = '0;
    for (int j = POOL_ENTRIES - 1; j >= 0; j--) begin
      if (status_q[j] == ES_AVAILABLE && link_ext[j]) begin
        pick_found = 1'b1;
        pick_idx   = IDX_W'(j);
      end
    end
  end

  always_comb begin
    if (status_q[scan_q] != ES_DEAD || req_q.now_seconds < retry_q[scan_q]) begin
      scan_res = SR_PASS;
    end else if (rc_q[scan_q] >= cfg_i.max_recoveries) begin
      scan_res = SR_RETIRE;
    end else if (!recon_ext[scan_ext]) begin
      scan_res = SR_RECON_FAIL;
    end else if ((cfg_i.require_secure && !secure_ext[scan_ext]) || !prep_ext[scan_ext]) begin
      scan_res = SR_BUMP;
    end else begin
      scan_res = SR_SUCCESS;
    end
  end

  assign rc_inc    = (rc_q[scan_q] == 8'hFF) ? 8'hFF : rc_q[scan_q] + 8'd1;
  assign shift_amt = (rc_inc < 8'(cfg_i.max_backoff_shift)) ? rc_inc[4:0]
                                                            : cfg_i.max_backoff_shift;

  assign bk_x = BK_W'(cfg_i.backoff_base_ms) << shift_amt;
  assign y_hi = y_q[BK_Y_W-1:BK_SPLIT];
  assign y_lo = y_q[BK_SPLIT-1:0];
  assign prod = BK_PROD_W'(z_q) * BK_PROD_W'(BK_RCP);

  assign sum      = SUM_W'(req_q.now_seconds) + SUM_W'(quo_q);
  assign deadline = (|sum[SUM_W-1:TIME_W]) ? '1 : sum[TIME_W-1:0];

  assign rel_idx    = IDX_W'(req_q.entry_index);
  assign rel_in_use = (32'(req_q.entry_index) < 32'(POOL_ENTRIES)) &&
                      (status_q[rel_idx] == ES_IN_USE);
  assign err_inc    = (err_q[rel_idx] == 8'hFF) ? 8'hFF : err_q[rel_idx] + 8'd1;
  assign rel_dead   = req_q.use_failed && (err_inc >= cfg_i.dead_threshold);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < POOL_ENTRIES; j++) begin
        status_q[j] <= ES_AVAILABLE;
        err_q[j]    <= '0;
        rc_q[j]     <= '0;
        retry_q[j]  <= '0;
      end
      hc_q      <= HC_W'(POOL_ENTRIES);
      fail_q    <= '0;
      reset_q   <= '0;
      scan_q    <= '0;
      granted_q <= 1'b0;
      gidx_q    <= '0;
      dead_q    <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        scan_q    <= '0;
        granted_q <= 1'b0;
        gidx_q    <= '0;
        dead_q    <= 1'b0;
      end
      if (cmd_i.release_apply && rel_in_use) begin
        if (req_q.use_failed) begin
          err_q[rel_idx] <= err_inc;
          if (rel_dead) begin
            status_q[rel_idx] <= ES_DEAD;
            dead_q            <= 1'b1;
            if (hc_q != '0) begin
              hc_q <= hc_q - 1'b1;
            end
          end else begin
            status_q[rel_idx] <= ES_AVAILABLE;
          end
        end else begin
          status_q[rel_idx] <= ES_AVAILABLE;
          err_q[rel_idx]    <= '0;
        end
      end
      if (cmd_i.pick) begin
        status_q[pick_idx] <= ES_IN_USE;
        granted_q          <= 1'b1;
        gidx_q             <= pick_idx;
      end
      if (cmd_i.scan_apply) begin
        case (scan_res)
          SR_RETIRE: begin
            status_q[scan_q] <= ES_PERMANENT;
          end
          SR_RECON_FAIL: begin
            rc_q[scan_q] <= rc_inc;
            fail_q       <= fail_q + 32'd1;
          end
          SR_BUMP: begin
            rc_q[scan_q] <= rc_inc;
          end
          SR_SUCCESS: begin
            err_q[scan_q]    <= '0;
            rc_q[scan_q]     <= '0;
            retry_q[scan_q]  <= '0;
            reset_q          <= reset_q + 32'd1;
            status_q[scan_q] <= ES_IN_USE;
            granted_q        <= 1'b1;
            gidx_q           <= scan_q;
            if (hc_q < HC_W'(POOL_ENTRIES)) begin
              hc_q <= hc_q + 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.scan_next) begin
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.deadline) begin
        retry_q[scan_q] <= deadline;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.scan_apply && scan_res == SR_RECON_FAIL) begin
      y_q   <= bk_x[BK_W-1:BK_PRE_SH];
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      z_q   <= BK_Z_W'(y_hi) * BK_Z_W'(BK_HI_REM) + BK_Z_W'(y_lo);
      qh_q  <= BK_QUO_W'(y_hi) * BK_QUO_W'(BK_HI_QUO);
      quo_q <= qh_q + BK_QUO_W'(prod[BK_PROD_W-1:BK_RCP_SH]);
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign sts_o.is_release = req_q.action;
  assign sts_o.pick_found = pick_found;
  assign sts_o.scan_res   = scan_res;
  assign sts_o.scan_last  = (scan_q == IDX_W'(POOL_ENTRIES - 1));
  assign sts_o.div_done   = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

  assign rsp_o.granted        = granted_q;
  assign rsp_o.grant_index    = 3'(gidx_q);
  assign rsp_o.became_dead    = dead_q;
  assign rsp_o.healthy_total  = 4'(hc_q);
  assign rsp_o.failures_total = fail_q;
  assign rsp_o.resets_total   = reset_q;

endmodule

`default_nettype wire

// ===== src/rpha_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpha_ctrl
// Sequencer: decode, dead-entry walk, backoff division and result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module rpha_ctrl
  import rpha_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  dp_sts_t   sts_i,
  output dp_cmd_t   cmd_o,
  output logic      busy_o,
  output logic      done_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        if (sts_i.is_release || sts_i.pick_found) state_d = S_DONE;
        else state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.scan_res == SR_SUCCESS) state_d = S_DONE;
        else if (sts_i.scan_res == SR_RECON_FAIL) state_d = S_DIV;
        else if (sts_i.scan_last) state_d = S_DONE;
      end
      S_DIV: begin
        if (sts_i.div_done) state_d = S_DEADLINE;
      end
      S_DEADLINE: begin
        state_d = sts_i.scan_last ? S_DONE : S_SCAN;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = start_i;
      end
      S_DECODE: begin
        cmd_o.release_apply = sts_i.is_release;
        cmd_o.pick          = !sts_i.is_release && sts_i.pick_found;
      end
      S_SCAN: begin
        cmd_o.scan_apply = 1'b1;
        cmd_o.scan_next  = (sts_i.scan_res != SR_SUCCESS) &&
                           (sts_i.scan_res != SR_RECON_FAIL) && !sts_i.scan_last;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      S_DEADLINE: begin
        cmd_o.deadline  = 1'b1;
        cmd_o.scan_next = !sts_i.scan_last;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

`default_nettype wire
